// File: hdl/mzncc_pkg.sv
// Shared widths, types and constants of the masked correlation score block.
package mzncc_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int SUMW_W   = 37;
    localparam int SUMN_W   = 36;
    localparam int SQ_W     = 51;
    localparam int CROSS_W  = 52;
    localparam int SCORE_W  = 16;

    localparam int PROD1_W  = 2 * SAMPLE_W;
    localparam int LIMB_W   = 32;
    localparam int LIMBS    = 3;
    localparam int OPND_W   = LIMB_W * LIMBS;
    localparam int PROD_W   = 2 * OPND_W;
    localparam int BIG_W    = 100;
    localparam int SHIFT_W  = 16;
    localparam int QUO_W    = 32;
    localparam int ROOT_W   = 17;

    localparam logic [SCORE_W-1:0] SCORE_MAX = 16'h7FFF;
    localparam logic [ROOT_W-1:0]  ROOT_SAT  = 17'd32768;

    typedef struct packed {
        logic [SUMW_W-1:0]  wl;
        logic [SUMW_W-1:0]  wr;
        logic [SUMN_W-1:0]  w;
        logic [SQ_W-1:0]    sxx;
        logic [SQ_W-1:0]    syy;
        logic [CROSS_W-1:0] sxy;
    } sums_t;

    typedef struct packed {
        logic              start;
        logic [OPND_W-1:0] a;
        logic [OPND_W-1:0] b;
    } mul_req_t;

endpackage

// File: hdl/mzncc_mul.sv
// Shared multi-limb multiplier: one 32x32 partial product per cycle.
module mzncc_mul
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  mzncc_pkg::mul_req_t       req,
    output logic                      done,
    output logic [mzncc_pkg::PROD_W-1:0] product
);

    localparam int LW = mzncc_pkg::LIMB_W;

    logic [mzncc_pkg::OPND_W-1:0] a_reg, a_next;
    logic [mzncc_pkg::OPND_W-1:0] b_reg, b_next;
    logic [1:0] i_reg, i_next, j_reg, j_next;
    logic busy_reg, busy_next;
    logic [2*LW-1:0] prod_reg, prod_next;
    logic [2:0] pidx_reg, pidx_next;
    logic pv_reg, pv_next, plast_reg, plast_next;
    logic [mzncc_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic done_reg, done_next;

    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        i_next = i_reg;
        j_next = j_reg;
        busy_next = busy_reg;
        prod_next = prod_reg;
        pidx_next = pidx_reg;
        pv_next = 1'b0;
        plast_next = 1'b0;
        acc_next = acc_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            prod_next = (2*LW)'(a_reg[LW*i_reg +: LW]) * (2*LW)'(b_reg[LW*j_reg +: LW]);
            pidx_next = 3'(i_reg) + 3'(j_reg);
            pv_next = 1'b1;
            plast_next = (i_reg == 2'd2) && (j_reg == 2'd2);
            if (j_reg == 2'd2)
            begin
                j_next = 2'd0;
                i_next = i_reg + 2'd1;
                if (i_reg == 2'd2)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                j_next = j_reg + 2'd1;
            end
        end
        if (pv_reg)
        begin
            acc_next = acc_reg
                + (mzncc_pkg::PROD_W'(prod_reg) << (LW * int'(pidx_reg)));
            done_next = plast_reg;
        end
        if (req.start)
        begin
            a_next = req.a;
            b_next = req.b;
            i_next = 2'd0;
            j_next = 2'd0;
            busy_next = 1'b1;
            acc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            busy_reg <= 1'b0;
            prod_reg <= '0;
            pidx_reg <= '0;
            pv_reg <= 1'b0;
            plast_reg <= 1'b0;
            acc_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            i_reg <= i_next;
            j_reg <= j_next;
            busy_reg <= busy_next;
            prod_reg <= prod_next;
            pidx_reg <= pidx_next;
            pv_reg <= pv_next;
            plast_reg <= plast_next;
            acc_reg <= acc_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign product = acc_reg;

endmodule

// File: hdl/mzncc_accum.sv
// Pixel pipeline: weights the samples, forms the products and keeps the six sums.
module mzncc_accum
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 take,
    input  logic signed [mzncc_pkg::SAMPLE_W-1:0] lhs_sample,
    input  logic signed [mzncc_pkg::SAMPLE_W-1:0] rhs_sample,
    input  logic [mzncc_pkg::WEIGHT_W-1:0]       mask_weight,
    input  logic                                 last_pixel,
    output mzncc_pkg::sums_t                     snap,
    output logic                                 snap_valid,
    output logic                                 last_pending
);

    localparam int SW = mzncc_pkg::SAMPLE_W;
    localparam int PW = mzncc_pkg::PROD1_W;

    logic signed [SW:0] pl, pr;
    logic s1_valid_reg, s1_last_reg, s2_valid_reg, s2_last_reg;
    logic signed [SW-1:0] s1_wl_reg, s1_wr_reg, s2_wl_reg, s2_wr_reg;
    logic [mzncc_pkg::WEIGHT_W-1:0] s1_w_reg, s2_w_reg;
    logic signed [PW-1:0] s2_sxx_reg, s2_syy_reg, s2_sxy_reg;
    mzncc_pkg::sums_t sums_reg, sums_next;
    logic signed [SW+mzncc_pkg::WEIGHT_W:0] wprod_l, wprod_r;

    assign pl = {lhs_sample[SW-1], lhs_sample};
    assign pr = {rhs_sample[SW-1], rhs_sample};
    // Flooring divide by 2^16 is an arithmetic shift of the full product.
    assign wprod_l = pl * $signed({1'b0, mask_weight});
    assign wprod_r = pr * $signed({1'b0, mask_weight});

    always_comb
    begin
        sums_next.wl  = sums_reg.wl
            + {{(mzncc_pkg::SUMW_W-SW){s2_wl_reg[SW-1]}}, s2_wl_reg};
        sums_next.wr  = sums_reg.wr
            + {{(mzncc_pkg::SUMW_W-SW){s2_wr_reg[SW-1]}}, s2_wr_reg};
        sums_next.w   = sums_reg.w + mzncc_pkg::SUMN_W'(s2_w_reg);
        sums_next.sxx = sums_reg.sxx + mzncc_pkg::SQ_W'(unsigned'(s2_sxx_reg));
        sums_next.syy = sums_reg.syy + mzncc_pkg::SQ_W'(unsigned'(s2_syy_reg));
        sums_next.sxy = sums_reg.sxy
            + {{(mzncc_pkg::CROSS_W-PW){s2_sxy_reg[PW-1]}}, s2_sxy_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s2_last_reg <= 1'b0;
            s1_wl_reg <= '0;
            s1_wr_reg <= '0;
            s1_w_reg <= '0;
            s2_wl_reg <= '0;
            s2_wr_reg <= '0;
            s2_w_reg <= '0;
            s2_sxx_reg <= '0;
            s2_syy_reg <= '0;
            s2_sxy_reg <= '0;
            sums_reg <= '0;
        end
        else
        begin
            s1_valid_reg <= take;
            s1_last_reg <= take && last_pixel;
            if (take)
            begin
                s1_wl_reg <= wprod_l[PW-1:SW];
                s1_wr_reg <= wprod_r[PW-1:SW];
                s1_w_reg <= mask_weight;
            end
            s2_valid_reg <= s1_valid_reg;
            s2_last_reg <= s1_last_reg;
            if (s1_valid_reg)
            begin
                s2_wl_reg <= s1_wl_reg;
                s2_wr_reg <= s1_wr_reg;
                s2_w_reg <= s1_w_reg;
                s2_sxx_reg <= s1_wl_reg * s1_wl_reg;
                s2_syy_reg <= s1_wr_reg * s1_wr_reg;
                s2_sxy_reg <= s1_wl_reg * s1_wr_reg;
            end
            if (s2_valid_reg)
            begin
                sums_reg <= s2_last_reg ? '0 : sums_next;
            end
        end
    end

    assign snap = sums_next;
    assign snap_valid = s2_valid_reg && s2_last_reg;
    assign last_pending = (s1_valid_reg && s1_last_reg) || (s2_valid_reg && s2_last_reg);

endmodule

// File: hdl/mzncc_score.sv
// Score sequencer: drives the shared multiplier, then divides and takes the root.
module mzncc_score
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  mzncc_pkg::sums_t                  sums,
    output mzncc_pkg::mul_req_t               mul_req,
    input  logic                              mul_done,
    input  logic [mzncc_pkg::PROD_W-1:0]      mul_prod,
    output logic                              busy,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [mzncc_pkg::SCORE_W-1:0] score,
    output logic                              degenerate
);

    localparam int BW = mzncc_pkg::BIG_W;
    localparam int OW = mzncc_pkg::OPND_W;
    localparam int PW = mzncc_pkg::PROD_W;
    localparam int QW = mzncc_pkg::QUO_W;
    localparam int RW = mzncc_pkg::ROOT_W;
    localparam int SHW = mzncc_pkg::SHIFT_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_TEST, ST_RANGE, ST_DIV, ST_SQRT, ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        OP_A1, OP_A2, OP_B1, OP_B2, OP_N1, OP_N2, OP_AB, OP_NN
    } op_t;

    state_t state_reg, state_next;
    op_t op_reg, op_next;
    mzncc_pkg::sums_t sums_reg, sums_next;
    logic start_reg, start_next;
    logic [BW-1:0] ta_reg, ta_next, a_reg, a_next, b_reg, b_next, num_reg, num_next;
    logic [PW-1:0] d_reg, d_next, rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [QW-1:0] sq_op_reg, sq_op_next, sq_res_reg, sq_res_next, sq_one_reg, sq_one_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [RW-1:0] s_reg, s_next;
    logic degen_reg, degen_next;
    logic out_valid_reg, out_valid_next;
    logic [mzncc_pkg::SCORE_W-1:0] score_reg, score_next;
    logic degen_out_reg, degen_out_next;

    logic [mzncc_pkg::SUMW_W-1:0] sx_mag, sy_mag;
    logic [mzncc_pkg::CROSS_W-1:0] sxy_mag;
    logic [BW-1:0] p_lo, p_sh, a_abs, b_abs, num_abs, sxsy;
    logic [PW-1:0] rem_sh;
    logic [QW-1:0] sq_t;
    logic [RW-1:0] root_sum;
    logic [mzncc_pkg::SCORE_W-1:0] final_score;

    always_comb
    begin
        sx_mag  = sums_reg.wl[mzncc_pkg::SUMW_W-1] ? -sums_reg.wl : sums_reg.wl;
        sy_mag  = sums_reg.wr[mzncc_pkg::SUMW_W-1] ? -sums_reg.wr : sums_reg.wr;
        sxy_mag = sums_reg.sxy[mzncc_pkg::CROSS_W-1] ? -sums_reg.sxy : sums_reg.sxy;
        a_abs   = a_reg[BW-1] ? -a_reg : a_reg;
        b_abs   = b_reg[BW-1] ? -b_reg : b_reg;
        num_abs = num_reg[BW-1] ? -num_reg : num_reg;
        p_lo    = mul_prod[BW-1:0];
        p_sh    = {mul_prod[BW-SHW-1:0], {SHW{1'b0}}};
        sxsy    = (sums_reg.wl[mzncc_pkg::SUMW_W-1] ^ sums_reg.wr[mzncc_pkg::SUMW_W-1])
                  ? -p_sh : p_sh;
        rem_sh  = {rem_reg[PW-2:0], 1'b0};
        sq_t    = sq_res_reg + sq_one_reg;
        if (num_reg[BW-1])
        begin
            final_score = mzncc_pkg::SCORE_W'(~s_reg + RW'(1));
        end
        else if (s_reg > RW'(mzncc_pkg::SCORE_MAX))
        begin
            final_score = mzncc_pkg::SCORE_MAX;
        end
        else
        begin
            final_score = s_reg[mzncc_pkg::SCORE_W-1:0];
        end
        root_sum = '0;

        mul_req.start = start_reg;
        unique case (op_reg)
            OP_A1:
            begin
                mul_req.a = OW'(sums_reg.w);
                mul_req.b = OW'(sums_reg.sxx);
            end
            OP_A2:
            begin
                mul_req.a = OW'(sx_mag);
                mul_req.b = OW'(sx_mag);
            end
            OP_B1:
            begin
                mul_req.a = OW'(sums_reg.w);
                mul_req.b = OW'(sums_reg.syy);
            end
            OP_B2:
            begin
                mul_req.a = OW'(sy_mag);
                mul_req.b = OW'(sy_mag);
            end
            OP_N1:
            begin
                mul_req.a = OW'(sums_reg.w);
                mul_req.b = OW'(sxy_mag);
            end
            OP_N2:
            begin
                mul_req.a = OW'(sx_mag);
                mul_req.b = OW'(sy_mag);
            end
            OP_AB:
            begin
                mul_req.a = a_abs[OW-1:0];
                mul_req.b = b_abs[OW-1:0];
            end
            OP_NN:
            begin
                mul_req.a = num_abs[OW-1:0];
                mul_req.b = num_abs[OW-1:0];
            end
            default:
            begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase

        state_next = state_reg;
        op_next = op_reg;
        sums_next = sums_reg;
        start_next = 1'b0;
        ta_next = ta_reg;
        a_next = a_reg;
        b_next = b_reg;
        num_next = num_reg;
        d_next = d_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        sq_op_next = sq_op_reg;
        sq_res_next = sq_res_reg;
        sq_one_next = sq_one_reg;
        cnt_next = cnt_reg;
        s_next = s_reg;
        degen_next = degen_reg;
        out_valid_next = out_valid_reg && out_stall;
        score_next = score_reg;
        degen_out_next = degen_out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    sums_next = sums;
                    num_next = '0;
                    s_next = '0;
                    if (sums.w == '0)
                    begin
                        degen_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        degen_next = 1'b0;
                        op_next = OP_A1;
                        start_next = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    start_next = 1'b1;
                    unique case (op_reg)
                        OP_A1:
                        begin
                            ta_next = p_lo;
                            op_next = OP_A2;
                        end
                        OP_A2:
                        begin
                            a_next = ta_reg - p_sh;
                            op_next = OP_B1;
                        end
                        OP_B1:
                        begin
                            ta_next = p_lo;
                            op_next = OP_B2;
                        end
                        OP_B2:
                        begin
                            b_next = ta_reg - p_sh;
                            start_next = 1'b0;
                            state_next = ST_TEST;
                        end
                        OP_N1:
                        begin
                            ta_next = sums_reg.sxy[mzncc_pkg::CROSS_W-1] ? -p_lo : p_lo;
                            op_next = OP_N2;
                        end
                        OP_N2:
                        begin
                            num_next = ta_reg - sxsy;
                            op_next = OP_AB;
                        end
                        OP_AB:
                        begin
                            d_next = mul_prod;
                            op_next = OP_NN;
                        end
                        OP_NN:
                        begin
                            rem_next = mul_prod;
                            start_next = 1'b0;
                            state_next = ST_RANGE;
                        end
                        default:
                        begin
                            start_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_TEST:
            begin
                // Only the sign of the variance product matters.
                if (a_reg == '0 || b_reg == '0 || a_reg[BW-1] != b_reg[BW-1])
                begin
                    degen_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    op_next = OP_N1;
                    start_next = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_RANGE:
            begin
                // num^2 at or above A*B means a magnitude of one or more.
                if (rem_reg >= d_reg)
                begin
                    s_next = mzncc_pkg::ROOT_SAT;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = '0;
                    q_next = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_sh >= d_reg)
                begin
                    rem_next = rem_sh - d_reg;
                    q_next = {q_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next = {q_reg[QW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    sq_op_next = q_next;
                    sq_res_next = '0;
                    sq_one_next = QW'(1) << (QW - 2);
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_op_reg >= sq_t)
                begin
                    sq_op_next = sq_op_reg - sq_t;
                    sq_res_next = (sq_res_reg >> 1) + sq_one_reg;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                sq_one_next = sq_one_reg >> 2;
                if (sq_one_reg == QW'(1))
                begin
                    // Largest s with (2s-1)^2 not above the quotient.
                    root_sum = sq_res_next[RW-1:0] + RW'(1);
                    s_next = root_sum >> 1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    degen_out_next = degen_reg;
                    score_next = degen_reg ? '0 : final_score;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_A1;
            sums_reg <= '0;
            start_reg <= 1'b0;
            ta_reg <= '0;
            a_reg <= '0;
            b_reg <= '0;
            num_reg <= '0;
            d_reg <= '0;
            rem_reg <= '0;
            q_reg <= '0;
            sq_op_reg <= '0;
            sq_res_reg <= '0;
            sq_one_reg <= '0;
            cnt_reg <= '0;
            s_reg <= '0;
            degen_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            score_reg <= '0;
            degen_out_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            sums_reg <= sums_next;
            start_reg <= start_next;
            ta_reg <= ta_next;
            a_reg <= a_next;
            b_reg <= b_next;
            num_reg <= num_next;
            d_reg <= d_next;
            rem_reg <= rem_next;
            q_reg <= q_next;
            sq_op_reg <= sq_op_next;
            sq_res_reg <= sq_res_next;
            sq_one_reg <= sq_one_next;
            cnt_reg <= cnt_next;
            s_reg <= s_next;
            degen_reg <= degen_next;
            out_valid_reg <= out_valid_next;
            score_reg <= score_next;
            degen_out_reg <= degen_out_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign score = score_reg;
    assign degenerate = degen_out_reg;

endmodule

// File: hdl/masked_zncc_score_top.sv
// Top level of the masked zero-normalized cross-correlation score block.
// Pixels are taken one per cycle while in_stall is low. Each pixel beat is weighted
// and accumulated through a two-stage pipeline. When a beat marked last reaches the
// sums, they are handed to the score sequencer and cleared, and the input stalls
// until the score is placed in the output register. The work after the last pixel
// beat is eight wide products on one shared 32x32 multiplier (nine partial products
// plus hand-off each), a 32-step restoring divide and a 16-step square root. A zero
// weight sum or a failed variance test ends the work early, and a magnitude of one
// or more skips the divide and the root. Pixels of the next image are taken again
// while the finished score waits to be read.
module masked_zncc_score_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mzncc_pkg::SAMPLE_W-1:0] lhs_sample,
    input  logic signed [mzncc_pkg::SAMPLE_W-1:0] rhs_sample,
    input  logic [mzncc_pkg::WEIGHT_W-1:0]       mask_weight,
    input  logic                                 last_pixel,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mzncc_pkg::SCORE_W-1:0] score,
    output logic                                 degenerate
);

    logic take;
    logic snap_valid, last_pending, busy, mul_done;
    mzncc_pkg::sums_t snap;
    mzncc_pkg::mul_req_t mul_req;
    logic [mzncc_pkg::PROD_W-1:0] mul_prod;

    assign in_stall = busy || last_pending;
    assign take = in_valid && !in_stall;

    mzncc_accum u_accum
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .lhs_sample   (lhs_sample),
        .rhs_sample   (rhs_sample),
        .mask_weight  (mask_weight),
        .last_pixel   (last_pixel),
        .snap         (snap),
        .snap_valid   (snap_valid),
        .last_pending (last_pending)
    );

    mzncc_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .done    (mul_done),
        .product (mul_prod)
    );

    mzncc_score u_score
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (snap_valid),
        .sums       (snap),
        .mul_req    (mul_req),
        .mul_done   (mul_done),
        .mul_prod   (mul_prod),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .score      (score),
        .degenerate (degenerate)
    );

endmodule
